// ===== rtl/running_minmax_normalizer_defines.svh =====
// Assertion macros for the running min/max normaliser.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef RUNNING_MINMAX_NORMALIZER_DEFINES_SVH
`define RUNNING_MINMAX_NORMALIZER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle
`define RMN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define RMN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rmn_pkg.sv =====
// Shared constants and types for the running min/max normaliser.
// Used by rmn_div and running_minmax_normalizer; depends on nothing.
package rmn_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int FRACTION_BITS = 16;

  // Fraction is Q1.FRACTION_BITS, so one extra integer bit
  localparam int FRAC_W      = FRACTION_BITS + 1;
  localparam int CNT_W       = $clog2(FRAC_W + 1);
  localparam int S_TDATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int M_TDATA_W   = ((FRAC_W + 7) / 8) * 8;

  localparam logic [FRAC_W-1:0] ONE_FIXED = FRAC_W'(1) << FRACTION_BITS;

  // Item kinds carried on the input tuser
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_RESET  = 1'b1;

  // Divider request and status
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

// ===== rtl/running_minmax_normalizer.sv =====
// A sample item passes through S_PREP (span and offset), the bit-serial restoring divider
// (FRAC_W quotient bits) and S_DONE (output load); a zero range skips the divider.
// No new item is accepted until the last sample's result is loaded into the output register.
// A reset item updates the bounds in its accept cycle and gives no result.
// rst (synchronous, active high) clears both bounds to zero and empties the output register.
// Depends on rmn_pkg, rmn_div and running_minmax_normalizer_defines.svh.
module running_minmax_normalizer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [rmn_pkg::S_TDATA_W-1:0]      s_tdata,   // [15:0] sample
  input  logic                               s_tuser,   // [0] action
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [rmn_pkg::M_TDATA_W-1:0]      m_tdata    // [16:0] fraction, rest zero
);
  import rmn_pkg::*;
  `include "running_minmax_normalizer_defines.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  state_t                          state;
  logic signed [SAMPLE_WIDTH-1:0]  running_max;
  logic signed [SAMPLE_WIDTH-1:0]  running_min;
  logic signed [SAMPLE_WIDTH-1:0]  smp;
  logic [FRAC_W-1:0]               result;

  logic signed [SAMPLE_WIDTH-1:0]  sample_in;
  logic signed [SAMPLE_WIDTH-1:0]  running_max_next;
  logic signed [SAMPLE_WIDTH-1:0]  running_min_next;
  logic [SAMPLE_WIDTH-1:0]         span;
  logic [SAMPLE_WIDTH-1:0]         offset;
  logic [FRAC_W-1:0]               div_q;
  div_req_t                        div_req;
  div_rsp_t                        div_rsp;

  assign s_tready  = (state == S_IDLE);
  assign sample_in = s_tdata[SAMPLE_WIDTH-1:0];

  // Widen the bounds so that they include the incoming sample
  always_comb begin
    running_max_next = (sample_in > running_max) ? sample_in : running_max;
    running_min_next = (sample_in < running_min) ? sample_in : running_min;
  end

  // Span and offset both fit unsigned, since min <= sample <= max
  assign span   = SAMPLE_WIDTH'(running_max - running_min);
  assign offset = SAMPLE_WIDTH'(smp - running_min);

  assign div_req.start = (state == S_PREP) && (span != '0);

  rmn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (offset),
    .divisor  (span),
    .rsp      (div_rsp),
    .quotient (div_q)
  );

  // Sequencer, bounds and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      running_max <= '0;
      running_min <= '0;
    end else begin
      // Drop the item once taken, unless a new one is loaded this cycle
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser == ACT_RESET) begin
              running_max <= sample_in;
              running_min <= sample_in;
            end else begin
              running_max <= running_max_next;
              running_min <= running_min_next;
              smp         <= sample_in;
              state       <= S_PREP;
            end
          end
        end
        S_PREP: begin
          if (span == '0) begin
            result <= '0;
            state  <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            result <= div_q;
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= M_TDATA_W'(result);
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RMN_ASSERT_NOW(a_ready_div_idle, clk, rst, s_tready, !div_rsp.busy, "accepting while divider busy")
  `RMN_ASSERT_NOW(a_bounds_order, clk, rst, 1'b1, running_min <= running_max, "min above max")
  `RMN_ASSERT_NOW(a_frac_range, clk, rst, m_tvalid, m_tdata[FRAC_W-1:0] <= ONE_FIXED, "fraction above one")
  `RMN_ASSERT_NEXT(a_done_to_out, clk, rst, div_rsp.done, state == S_DONE, "divider result not taken")

endmodule

// ===== rtl/rmn_div.sv =====
// Restoring divider producing one quotient bit per cycle.
// Depends on rmn_pkg for widths and the request/status structs.
module rmn_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rmn_pkg::div_req_t                     req,
  input  logic [rmn_pkg::SAMPLE_WIDTH-1:0]      dividend,
  input  logic [rmn_pkg::SAMPLE_WIDTH-1:0]      divisor,
  output rmn_pkg::div_rsp_t                     rsp,
  output logic [rmn_pkg::FRAC_W-1:0]            quotient
);
  import rmn_pkg::*;

  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic [SAMPLE_WIDTH:0]   rem;
  logic [SAMPLE_WIDTH:0]   dsor;
  logic [FRAC_W-1:0]       quo;
  logic [SAMPLE_WIDTH:0]   diff;
  logic                    qbit;
  logic [SAMPLE_WIDTH:0]   rem_sel;

  // Trial subtraction of the divisor from the partial remainder
  always_comb begin
    diff    = rem - dsor;
    qbit    = (rem >= dsor);
    rem_sel = qbit ? diff : rem;
  end

  assign quotient = {quo[FRAC_W-2:0], qbit};
  assign rsp.busy = busy;
  assign rsp.done = busy && (cnt == CNT_W'(1));

  // Load operands on start, then shift one quotient bit in each cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start && !busy) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(FRAC_W);
      rem  <= {1'b0, dividend};
      dsor <= {1'b0, divisor};
      quo  <= '0;
    end else if (busy) begin
      rem <= {rem_sel[SAMPLE_WIDTH-1:0], 1'b0};
      quo <= {quo[FRAC_W-2:0], qbit};
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
